### hdl/stor_pkg.sv
package stor_pkg;

   localparam int unsigned SEQ_W  = 32;
   localparam int unsigned LEN_W  = 6;
   localparam int unsigned BYTE_W = 8;

   localparam logic [1:0] FUNC_PUSH        = 2'd0;
   localparam logic [1:0] FUNC_ATTACH_END  = 2'd1;
   localparam logic [1:0] FUNC_ATTACH_HIST = 2'd2;
   localparam logic [1:0] FUNC_READ        = 2'd3;

   localparam logic [1:0] ST_ACCEPTED    = 2'd0;
   localparam logic [1:0] ST_ENTRY_BYTE  = 2'd1;
   localparam logic [1:0] ST_NOTHING_NEW = 2'd2;
   localparam logic [1:0] ST_STALE       = 2'd3;

   localparam int unsigned CMD_DEPTH = 2;
   localparam int unsigned CMD_PW    = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CW    = $clog2(CMD_DEPTH + 1);

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PW    = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CW    = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH_BYTE,
      OP_COMMIT,
      OP_ATTACH_END,
      OP_ATTACH_HIST,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_COPY,
      BK_COMMIT,
      BK_ACK,
      BK_READ_TAG,
      BK_STREAM
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [1:0]          reader_id;
      logic                reader_ok;
      logic [BYTE_W-1:0]   data_byte;
      logic [SEQ_W-1:0]    history_count;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [BYTE_W-1:0]   out_byte;
      logic [LEN_W-1:0]    entry_length;
      logic                last;
      logic [SEQ_W-1:0]    pending;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic almost_full;
   } level_type;

endpackage

### hdl/stor_front.sv
module stor_front #(
   parameter int unsigned READER_COUNT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            func,
   input  logic [1:0]            reader_id,
   input  logic [7:0]            data_byte,
   input  logic [31:0]           history_count,
   input  logic                  cmd_pop,
   output logic                  cmd_valid,
   output stor_pkg::cmd_type     cmd
);
   import stor_pkg::*;

   cmd_type             q_ff [CMD_DEPTH];
   logic [CMD_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CW-1:0]   count_ff, count_in;
   cmd_type             entry;
   logic                accept;
   logic                take;

   always_comb begin
      entry.reader_id     = reader_id;
      entry.reader_ok     = ({30'd0, reader_id} < 32'(READER_COUNT));
      entry.data_byte     = data_byte;
      entry.history_count = history_count;
      case (func)
         FUNC_PUSH: begin
            entry.op = (data_byte == 8'd0) ? OP_COMMIT : OP_PUSH_BYTE;
         end
         FUNC_ATTACH_END: begin
            entry.op = OP_ATTACH_END;
         end
         FUNC_ATTACH_HIST: begin
            entry.op = OP_ATTACH_HIST;
         end
         default: begin
            entry.op = OP_READ;
         end
      endcase
   end

   assign full      = (count_ff == CMD_CW'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + CMD_PW'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + CMD_PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CW'(accept) - CMD_CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### hdl/stor_rsp_queue.sv
module stor_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_push,
   input  stor_pkg::rsp_type     rsp_in,
   output stor_pkg::level_type   level,
   output logic                  empty,
   input  logic                  pop,
   output stor_pkg::rsp_type     head
);
   import stor_pkg::*;

   rsp_type             q_ff [RSP_DEPTH];
   logic [RSP_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0]   count_ff, count_in;
   logic                take;

   assign empty             = (count_ff == '0);
   assign level.full        = (count_ff == RSP_CW'(RSP_DEPTH));
   assign level.almost_full = (count_ff >= RSP_CW'(RSP_DEPTH - 1));
   assign head              = q_ff[rd_ptr_ff];
   assign take              = pop && !empty;

   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + RSP_PW'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + RSP_PW'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CW'(rsp_push) - RSP_CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

### hdl/stor_back.sv
module stor_back #(
   parameter int unsigned SLOT_COUNT   = 16,
   parameter int unsigned ENTRY_BYTES  = 64,
   parameter int unsigned READER_COUNT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  stor_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   input  stor_pkg::level_type   level,
   output logic                  rsp_push,
   output stor_pkg::rsp_type     rsp
);
   import stor_pkg::*;

   localparam int unsigned IW         = $clog2(SLOT_COUNT);
   localparam int unsigned OW         = $clog2(ENTRY_BYTES);
   localparam int unsigned RW         = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
   localparam int unsigned SLOT_WORDS = SLOT_COUNT * (1 << OW);
   localparam logic [SEQ_W-1:0] RING_SPAN   = SEQ_W'(SLOT_COUNT);
   localparam logic [SEQ_W-1:0] SMALL_LIMIT = SEQ_W'(SLOT_COUNT + 1);
   localparam logic [LEN_W-1:0] FILL_MAX    = LEN_W'(ENTRY_BYTES - 1);
   localparam logic [IW-1:0]    LAST_IDX    = IW'(SLOT_COUNT - 1);
   localparam logic [IW:0]      SPAN_WIDE   = (IW + 1)'(SLOT_COUNT);

   function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] s);
      return (s == LAST_IDX) ? '0 : s + IW'(1);
   endfunction

   logic [BYTE_W-1:0]   hold_mem [ENTRY_BYTES];
   logic [BYTE_W-1:0]   slot_mem [SLOT_WORDS];
   logic [SEQ_W-1:0]    tag_mem  [SLOT_COUNT];
   logic [LEN_W-1:0]    len_mem  [SLOT_COUNT];

   back_state_type      state_ff, state_in;
   logic [SEQ_W-1:0]    ws_ff, ws_in;
   logic [IW-1:0]       wp_idx_ff, wp_idx_in;
   logic                ring_full_ff, ring_full_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [SEQ_W-1:0]    cursor_ff [READER_COUNT];
   logic [SEQ_W-1:0]    cursor_in [READER_COUNT];
   logic [IW-1:0]       ridx_ff   [READER_COUNT];
   logic [IW-1:0]       ridx_in   [READER_COUNT];
   logic                rd_vld_ff, rd_vld_in;
   logic                copy_vld_ff, copy_vld_in;

   cmd_type             cmd_ff, cmd_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [IW-1:0]       rd_slot_ff, rd_slot_in;
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [SEQ_W-1:0]    pend_ff, pend_in;
   logic                rd_last_ff, rd_last_in;
   logic [OW-1:0]       copy_off_ff, copy_off_in;
   logic [BYTE_W-1:0]   hold_q_ff;
   logic [BYTE_W-1:0]   byte_q_ff;
   logic [SEQ_W-1:0]    tag_q_ff;
   logic [LEN_W-1:0]    len_q_ff;

   logic                hold_we, hold_re, slot_re, tag_we, tag_re;
   logic [OW-1:0]       hold_ra;
   logic [IW+OW-1:0]    slot_ra;
   logic [IW-1:0]       tag_ra;

   cmd_type             sel;
   logic [RW-1:0]       ri;
   logic [SEQ_W-1:0]    cur;
   logic [SEQ_W-1:0]    pend_now;
   logic                small_ws;
   logic [SEQ_W-1:0]    span;
   logic                hist_hit;
   logic [IW-1:0]       hist_lo;
   logic [IW:0]         back_wide;
   logic [SEQ_W-1:0]    floor_seq;
   logic [SEQ_W-1:0]    read_seq;
   logic [IW-1:0]       read_slot;
   logic                written;
   logic                hit;
   logic                can_emit;

   always_comb begin
      sel       = (state_ff == BK_IDLE) ? cmd : cmd_ff;
      ri        = RW'(sel.reader_id);
      cur       = cursor_ff[ri];
      pend_now  = (sel.reader_ok && (ws_ff > cur)) ? ws_ff - cur : '0;
      small_ws  = (ws_ff <= SMALL_LIMIT);
      span      = small_ws ? ws_ff - SEQ_W'(1) : RING_SPAN;
      floor_seq = ws_ff - RING_SPAN;
      hist_hit  = (sel.history_count != '0) && (sel.history_count < span);
      hist_lo   = sel.history_count[IW-1:0];
      back_wide = {1'b0, wp_idx_ff} + SPAN_WIDE - {1'b0, hist_lo};
      if (!small_ws && (cur < floor_seq)) begin
         read_seq  = floor_seq;
         read_slot = wp_idx_ff;
      end else begin
         read_seq  = cur;
         read_slot = ridx_ff[ri];
      end
      written  = ring_full_ff
                 || ({{(SEQ_W - IW){1'b0}}, rd_slot_ff} < ws_ff - SEQ_W'(1));
      hit      = written && (tag_q_ff == seq_ff);
      can_emit = !level.full && !rd_vld_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      wp_idx_in    = wp_idx_ff;
      ring_full_in = ring_full_ff;
      fill_in      = fill_ff;
      cursor_in    = cursor_ff;
      ridx_in      = ridx_ff;
      rd_vld_in    = 1'b0;
      copy_vld_in  = 1'b0;
      cmd_in       = cmd_ff;
      seq_in       = seq_ff;
      rd_slot_in   = rd_slot_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      rd_last_in   = rd_last_ff;
      copy_off_in  = copy_off_ff;
      hold_we      = 1'b0;
      hold_re      = 1'b0;
      hold_ra      = count_ff[OW-1:0];
      slot_re      = 1'b0;
      slot_ra      = {rd_slot_ff, count_ff[OW-1:0]};
      tag_we       = 1'b0;
      tag_re       = 1'b0;
      tag_ra       = read_slot;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp.status       = ST_ACCEPTED;
      rsp.out_byte     = '0;
      rsp.entry_length = '0;
      rsp.last         = 1'b1;
      rsp.pending      = pend_now;

      if (rd_vld_ff) begin
         rsp_push         = 1'b1;
         rsp.status       = ST_ENTRY_BYTE;
         rsp.out_byte     = byte_q_ff;
         rsp.entry_length = len_ff;
         rsp.last         = rd_last_ff;
         rsp.pending      = pend_ff;
      end

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && can_emit) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.op)
                  OP_PUSH_BYTE: begin
                     if (fill_ff < FILL_MAX) begin
                        hold_we = 1'b1;
                        fill_in = fill_ff + LEN_W'(1);
                     end
                     rsp_push = 1'b1;
                  end
                  OP_COMMIT: begin
                     count_in = '0;
                     state_in = (fill_ff == '0) ? BK_COMMIT : BK_COPY;
                  end
                  OP_ATTACH_END: begin
                     if (cmd.reader_ok) begin
                        cursor_in[ri] = ws_ff;
                        ridx_in[ri]   = wp_idx_ff;
                     end
                     state_in = BK_ACK;
                  end
                  OP_ATTACH_HIST: begin
                     if (cmd.reader_ok) begin
                        if (hist_hit) begin
                           cursor_in[ri] = ws_ff - cmd.history_count;
                           ridx_in[ri]   = (back_wide >= SPAN_WIDE)
                                           ? IW'(back_wide - SPAN_WIDE)
                                           : back_wide[IW-1:0];
                        end else if (small_ws) begin
                           cursor_in[ri] = SEQ_W'(1);
                           ridx_in[ri]   = '0;
                        end else begin
                           cursor_in[ri] = floor_seq;
                           ridx_in[ri]   = wp_idx_ff;
                        end
                     end
                     state_in = BK_ACK;
                  end
                  OP_READ: begin
                     if (!cmd.reader_ok || (cur >= ws_ff)) begin
                        rsp_push    = 1'b1;
                        rsp.status  = ST_NOTHING_NEW;
                        rsp.pending = '0;
                     end else begin
                        tag_re        = 1'b1;
                        cursor_in[ri] = read_seq + SEQ_W'(1);
                        ridx_in[ri]   = slot_next(read_slot);
                        seq_in        = read_seq;
                        rd_slot_in    = read_slot;
                        state_in      = BK_READ_TAG;
                     end
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         BK_COPY: begin
            hold_re     = 1'b1;
            copy_vld_in = 1'b1;
            copy_off_in = count_ff[OW-1:0];
            count_in    = count_ff + LEN_W'(1);
            if (count_ff == fill_ff - LEN_W'(1)) begin
               state_in = BK_COMMIT;
            end
         end
         BK_COMMIT: begin
            tag_we    = 1'b1;
            ws_in     = ws_ff + SEQ_W'(1);
            wp_idx_in = slot_next(wp_idx_ff);
            fill_in   = '0;
            if (wp_idx_ff == LAST_IDX) begin
               ring_full_in = 1'b1;
            end
            state_in = BK_ACK;
         end
         BK_ACK: begin
            if (can_emit) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_READ_TAG: begin
            if (can_emit) begin
               if (!hit) begin
                  rsp_push   = 1'b1;
                  rsp.status = ST_STALE;
                  state_in   = BK_IDLE;
               end else if (len_q_ff == '0) begin
                  rsp_push   = 1'b1;
                  rsp.status = ST_ENTRY_BYTE;
                  state_in   = BK_IDLE;
               end else begin
                  len_in   = len_q_ff;
                  pend_in  = pend_now;
                  count_in = '0;
                  state_in = BK_STREAM;
               end
            end
         end
         BK_STREAM: begin
            if (!level.full && !(rd_vld_ff && level.almost_full)) begin
               slot_re    = 1'b1;
               rd_vld_in  = 1'b1;
               rd_last_in = (count_ff == len_ff - LEN_W'(1));
               count_in   = count_ff + LEN_W'(1);
               if (count_ff == len_ff - LEN_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ws_ff        <= SEQ_W'(1);
         wp_idx_ff    <= '0;
         ring_full_ff <= 1'b0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         copy_vld_ff  <= 1'b0;
         for (int r = 0; r < READER_COUNT; r++) begin
            cursor_ff[r] <= SEQ_W'(1);
            ridx_ff[r]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         wp_idx_ff    <= wp_idx_in;
         ring_full_ff <= ring_full_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         copy_vld_ff  <= copy_vld_in;
         cursor_ff    <= cursor_in;
         ridx_ff      <= ridx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      seq_ff      <= seq_in;
      rd_slot_ff  <= rd_slot_in;
      count_ff    <= count_in;
      len_ff      <= len_in;
      pend_ff     <= pend_in;
      rd_last_ff  <= rd_last_in;
      copy_off_ff <= copy_off_in;
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[fill_ff[OW-1:0]] <= cmd.data_byte;
      end
      if (hold_re) begin
         hold_q_ff <= hold_mem[hold_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (copy_vld_ff) begin
         slot_mem[{wp_idx_ff, copy_off_ff}] <= hold_q_ff;
      end
      if (slot_re) begin
         byte_q_ff <= slot_mem[slot_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wp_idx_ff] <= ws_ff;
         len_mem[wp_idx_ff] <= fill_ff;
      end
      if (tag_re) begin
         tag_q_ff <= tag_mem[tag_ra];
         len_q_ff <= len_mem[tag_ra];
      end
   end

endmodule

### hdl/seq_tagged_overwrite_ring.sv
// Channel    Direction  Handshake    Payload
// request    in         push / full  req_func, req_reader_id, req_data_byte, req_history_count
// response   out        empty / pop  rsp_status, rsp_out_byte, rsp_entry_length, rsp_last,
//                                    rsp_pending
//
// A byte push goes into the holding memory. A commit is a byte-wide copy from the holding
// memory into the slot memory. A read that finds nothing new is answered from the idle state,
// a stale or empty slot after its tag is read, and any other entry streams one byte per cycle
// from the slot memory read port while the response queue has room.
// Reset needs no clearing pass; slots that were never committed are told apart by the write
// count. Either side may stall at any time.
module seq_tagged_overwrite_ring #(
   parameter int unsigned SLOT_COUNT   = 16,
   parameter int unsigned ENTRY_BYTES  = 64,
   parameter int unsigned READER_COUNT = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [1:0]     req_func,
   input  logic [1:0]     req_reader_id,
   input  logic [7:0]     req_data_byte,
   input  logic [31:0]    req_history_count,
   output logic           empty,
   input  logic           pop,
   output logic [1:0]     rsp_status,
   output logic [7:0]     rsp_out_byte,
   output logic [5:0]     rsp_entry_length,
   output logic           rsp_last,
   output logic [31:0]    rsp_pending
);
   import stor_pkg::*;

   logic       cmd_valid;
   logic       cmd_pop;
   cmd_type    cmd;
   level_type  level;
   logic       rsp_push;
   rsp_type    rsp;
   rsp_type    head;

   stor_front #(
      .READER_COUNT (READER_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .func          (req_func),
      .reader_id     (req_reader_id),
      .data_byte     (req_data_byte),
      .history_count (req_history_count),
      .cmd_pop       (cmd_pop),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   stor_back #(
      .SLOT_COUNT   (SLOT_COUNT),
      .ENTRY_BYTES  (ENTRY_BYTES),
      .READER_COUNT (READER_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .level     (level),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   stor_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp),
      .level    (level),
      .empty    (empty),
      .pop      (pop),
      .head     (head)
   );

   assign rsp_status       = head.status;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_entry_length = head.entry_length;
   assign rsp_last         = head.last;
   assign rsp_pending      = head.pending;

endmodule

### tb/seq_tagged_overwrite_ring_tb.sv
`timescale 1ns / 1ps

module seq_tagged_overwrite_ring_tb;
   import stor_pkg::*;

   localparam int SLOTS         = 16;
   localparam int ENTRY         = 64;
   localparam int READERS       = 4;
   localparam int RANDOM_ITEMS  = 170;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 300;

   class ring_replica;
      logic [7:0]  slot_data [SLOTS][ENTRY];
      logic [31:0] slot_seq [SLOTS];
      logic [5:0]  slot_len [SLOTS];
      logic [7:0]  held [ENTRY];
      logic [5:0]  held_len;
      logic [31:0] next_seq;
      logic [31:0] cursor [READERS];
      rsp_type     expected_rsp [$];
      int          mismatches;

      function new();
         next_seq = 32'd1;
         held_len = '0;
         mismatches = 0;
         foreach (slot_seq[i]) begin
            slot_seq[i] = '0;
            slot_len[i] = '0;
         end
         foreach (held[i]) held[i] = '0;
         foreach (cursor[r]) cursor[r] = 32'd1;
      endfunction

      function logic [31:0] lag(logic [1:0] rid);
         if (rid < READERS && next_seq > cursor[rid]) return next_seq - cursor[rid];
         return '0;
      endfunction

      function void expect_rsp(logic [1:0] st, logic [7:0] data, logic [5:0] n, logic lst,
                               logic [31:0] pend);
         rsp_type r;
         r.status = st;
         r.out_byte = data;
         r.entry_length = n;
         r.last = lst;
         r.pending = pend;
         expected_rsp.push_back(r);
      endfunction

      function void note_transfer(logic [1:0] func, logic [1:0] rid, logic [7:0] data,
                                  logic [31:0] hist);
         logic [31:0] oldest;
         logic [31:0] seq;
         int          idx;
         int          i;
         case (func)
            FUNC_PUSH: begin
               if (data != 0) begin
                  if (held_len < ENTRY - 1) begin
                     held[held_len] = data;
                     held_len++;
                  end
               end else begin
                  idx = (next_seq - 1) % SLOTS;
                  for (i = 0; i < held_len; i++) slot_data[idx][i] = held[i];
                  slot_len[idx] = held_len;
                  slot_seq[idx] = next_seq;
                  next_seq++;
                  held_len = '0;
               end
            end
            FUNC_ATTACH_END: begin
               if (rid < READERS) cursor[rid] = next_seq;
            end
            FUNC_ATTACH_HIST: begin
               if (rid < READERS) begin
                  oldest = (next_seq <= SLOTS + 1) ? 32'd1 : next_seq - SLOTS;
                  if (hist > 0 && hist < next_seq - oldest) cursor[rid] = next_seq - hist;
                  else cursor[rid] = oldest;
               end
            end
            default: begin
               if (rid >= READERS || cursor[rid] >= next_seq) begin
                  expect_rsp(ST_NOTHING_NEW, 8'd0, 6'd0, 1'b1, lag(rid));
                  return;
               end
               if (next_seq > SLOTS + 1 && cursor[rid] < next_seq - SLOTS)
                  cursor[rid] = next_seq - SLOTS;
               seq = cursor[rid];
               idx = (seq - 1) % SLOTS;
               cursor[rid] = seq + 1;
               if (slot_seq[idx] != seq) begin
                  expect_rsp(ST_STALE, 8'd0, 6'd0, 1'b1, lag(rid));
               end else if (slot_len[idx] == 0) begin
                  expect_rsp(ST_ENTRY_BYTE, 8'd0, 6'd0, 1'b1, lag(rid));
               end else begin
                  for (i = 0; i < slot_len[idx]; i++)
                     expect_rsp(ST_ENTRY_BYTE, slot_data[idx][i], slot_len[idx],
                                i == slot_len[idx] - 1, lag(rid));
               end
               return;
            end
         endcase
         expect_rsp(ST_ACCEPTED, 8'd0, 6'd0, 1'b1, lag(rid));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d byte %h len %0d last %0b pending %0d",
                        got.status, got.out_byte, got.entry_length, got.last, got.pending);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status || got.out_byte !== want.out_byte ||
             got.entry_length !== want.entry_length || got.last !== want.last ||
             got.pending !== want.pending) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d byte %h len %0d last %0b pending %0d, %s",
                        want.status, want.out_byte, want.entry_length, want.last,
                        want.pending,
                        $sformatf("got status %0d byte %h len %0d last %0b pending %0d",
                                  got.status, got.out_byte, got.entry_length, got.last,
                                  got.pending));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_func;
   logic [1:0]  req_reader_id;
   logic [7:0]  req_data_byte;
   logic [31:0] req_history_count;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic [5:0]  rsp_entry_length;
   logic        rsp_last;
   logic [31:0] rsp_pending;

   ring_replica board;
   bit          idle_on;
   bit          hold_req;
   int          hold_left;
   int          sent;
   int          cycles;

   seq_tagged_overwrite_ring #(
      .SLOT_COUNT(SLOTS),
      .ENTRY_BYTES(ENTRY),
      .READER_COUNT(READERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_func(req_func),
      .req_reader_id(req_reader_id),
      .req_data_byte(req_data_byte),
      .req_history_count(req_history_count),
      .empty(empty),
      .pop(pop),
      .rsp_status(rsp_status),
      .rsp_out_byte(rsp_out_byte),
      .rsp_entry_length(rsp_entry_length),
      .rsp_last(rsp_last),
      .rsp_pending(rsp_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         if (push && !full)
            board.note_transfer(req_func, req_reader_id, req_data_byte, req_history_count);
         if (pop && !empty) begin
            got.status = rsp_status;
            got.out_byte = rsp_out_byte;
            got.entry_length = rsp_entry_length;
            got.last = rsp_last;
            got.pending = rsp_pending;
            board.check_result(got);
         end
      end
   end

   // The receiver runs on its own; a requested hold-off is counted down here.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= !(idle_on && $urandom_range(99, 0) < 32);
         end
      end
   end

   task automatic send(input logic [1:0] func, input logic [1:0] rid, input logic [7:0] data,
                       input logic [31:0] hist);
      while (idle_on && $urandom_range(99, 0) < 32) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_func <= func;
      req_reader_id <= rid;
      req_data_byte <= data;
      req_history_count <= hist;
      push <= 1'b1;
      do @(posedge clock); while (full);
      sent++;
   endtask

   task automatic send_noise();
      send(2'($urandom_range(3, 1)), 2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
           $urandom);
   endtask

   task automatic send_message(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99, 0) < 8) send_noise();
         send(FUNC_PUSH, 2'($urandom_range(3, 0)), 8'($urandom_range(255, 1)), $urandom);
      end
      send(FUNC_PUSH, 2'($urandom_range(3, 0)), 8'd0, $urandom);
   endtask

   task automatic send_reads(input logic [1:0] rid, input int n);
      repeat (n) send(FUNC_READ, rid, 8'($urandom_range(255, 0)), $urandom);
   endtask

   function automatic logic [31:0] pick_history();
      case ($urandom_range(3, 0))
         0: return 32'd0;
         1: return $urandom_range(20, 1);
         2: return $urandom;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   initial begin
      int  pick;
      int  n;
      int  stop_at;
      bit  long_done;
      bit  pressure_done;
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_func = FUNC_PUSH;
      req_reader_id = 2'd0;
      req_data_byte = 8'd0;
      req_history_count = 32'd0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      hold_left = 0;
      sent = 0;
      cycles = 0;
      long_done = 1'b0;
      pressure_done = 1'b0;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send(FUNC_READ, 2'd0, 8'd0, 32'd0);
      send(FUNC_PUSH, 2'd1, 8'h01, 32'd0);
      send(FUNC_PUSH, 2'd2, 8'hFF, 32'hFFFF_FFFF);
      send(FUNC_PUSH, 2'd3, 8'h80, 32'd0);
      send(FUNC_PUSH, 2'd0, 8'h00, 32'd0);
      send(FUNC_PUSH, 2'd0, 8'h00, 32'd0);
      send_reads(2'd0, 3);
      send(FUNC_ATTACH_END, 2'd1, 8'd0, 32'd0);
      send(FUNC_READ, 2'd1, 8'hFF, 32'hFFFF_FFFF);
      send(FUNC_ATTACH_HIST, 2'd2, 8'd0, 32'd0);
      send(FUNC_ATTACH_HIST, 2'd3, 8'd0, 32'hFFFF_FFFF);
      send(FUNC_ATTACH_HIST, 2'd1, 8'd0, 32'd1);
      send(FUNC_READ, 2'd1, 8'd0, 32'd0);
      send(FUNC_READ, 2'd3, 8'd0, 32'd0);
      send(FUNC_READ, 2'd2, 8'd0, 32'd0);

      idle_on = 1'b0;
      stop_at = sent + RANDOM_ITEMS;
      while (sent < stop_at) begin
         if (sent > stop_at - RANDOM_ITEMS + 60) idle_on = 1'b1;
         if (!pressure_done && sent > stop_at - RANDOM_ITEMS + 100) begin
            pressure_done = 1'b1;
            hold_req = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            if (!long_done && sent > stop_at - RANDOM_ITEMS + 80) begin
               long_done = 1'b1;
               n = $urandom_range(69, 64);
            end else if ($urandom_range(19, 0) == 0) begin
               n = $urandom_range(40, 10);
            end else begin
               n = $urandom_range(6, 0);
            end
            send_message(n);
         end else if (pick < 75) begin
            send_reads(2'($urandom_range(3, 0)), $urandom_range(4, 1));
         end else if (pick < 85) begin
            send(FUNC_ATTACH_HIST, 2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                 pick_history());
         end else if (pick < 90) begin
            send(FUNC_ATTACH_END, 2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                 $urandom);
         end else begin
            send(FUNC_PUSH, 2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), $urandom);
         end
      end
      push <= 1'b0;
      @(posedge clock);

      while (board.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

### files.f
hdl/stor_pkg.sv
hdl/stor_front.sv
hdl/stor_rsp_queue.sv
hdl/stor_back.sv
hdl/seq_tagged_overwrite_ring.sv
tb/seq_tagged_overwrite_ring_tb.sv
